/* src/rsre_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rsre_pkg;

    localparam int CARRIER_W = 32;
    localparam int FRF_W     = 24;
    localparam int FRF_SHIFT = 19;

    // Hundredths of dBm to whole dBm: floor(x / 100) == (x * 5243) >> 19 for x <= 32768.
    localparam logic [12:0] CENTI_RECIP = 13'd5243;
    localparam int          CENTI_SHIFT = 19;
    localparam int          DBM_W       = 11;

    localparam logic [1:0] BW_125K = 2'd0;
    localparam logic [1:0] BW_250K = 2'd1;
    localparam logic [1:0] BW_500K = 2'd2;

    localparam logic [3:0] SF_MIN = 4'd7;
    localparam logic [3:0] SF_MAX = 4'd12;
    localparam logic [3:0] SF_11  = 4'd11;
    localparam logic [3:0] SF_12  = 4'd12;
    localparam logic [7:0] SF_DEFAULT_BITS = 8'h70;

    localparam logic [7:0] BW_NEW_125K = 8'h70;
    localparam logic [7:0] BW_NEW_250K = 8'h80;
    localparam logic [7:0] BW_NEW_500K = 8'h90;
    localparam logic [7:0] BW_OLD_125K = 8'h00;
    localparam logic [7:0] BW_OLD_250K = 8'h40;
    localparam logic [7:0] BW_OLD_500K = 8'h80;

    localparam logic [7:0] CFG1_IMPLICIT_CR = 8'h02;
    localparam logic [7:0] CFG1_OLD_CRC     = 8'h08;
    localparam logic [7:0] CFG1_OLD_LOWRATE = 8'h01;
    localparam logic [7:0] CFG2_FIXED       = 8'h04;
    localparam logic [7:0] CFG3_LOWRATE     = 8'h08;
    localparam logic [7:0] CFG3_AGC         = 8'h04;

    localparam logic [7:0] PA_HIGH_NIBBLE = 8'hf0;
    localparam logic [7:0] PA_SELECT      = 8'h80;
    localparam logic [7:0] PA_MAX_POWER   = 8'h70;
    localparam logic [7:0] PA_RFO_NEWER   = 8'h7e;
    localparam logic [7:0] DAC_KEEP       = 8'hf8;
    localparam logic [7:0] DAC_BOOST_ON   = 8'h07;
    localparam logic [7:0] DAC_BOOST_OFF  = 8'h04;
    localparam logic [3:0] NIB_MAX        = 4'hf;
    localparam logic [3:0] NIB_MIN        = 4'h0;

    // Configuration register indexes (byte address bit 2).
    localparam logic REG_CHIP_VARIANT = 1'b0;
    localparam logic REG_AMP_PATH     = 1'b1;

    typedef struct packed {
        logic [7:0] cfg1;
        logic [7:0] cfg2;
        logic [7:0] cfg3;
        logic       cfg3_valid;
    } modem_words_t;

    typedef struct packed {
        logic [7:0] pa_config;
        logic [7:0] pa_dac;
        logic       config_valid;
        logic       dac_valid;
    } pa_words_t;

    typedef struct packed {
        logic newer;
        logic boost;
    } radio_cfg_t;

endpackage

`default_nettype wire

/* src/rsre_frf_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsre_frf_div
    import rsre_pkg::*;
#(
    parameter int CRYSTAL_HZ = 32000000
)
(
    input  wire logic                 clk,
    input  wire logic [CARRIER_W-1:0] carrier_hz,
    output logic      [FRF_W-1:0]     frf_word
);

    localparam int CW = $clog2(CRYSTAL_HZ + 1);
    localparam int RW = CW + 1;
    localparam int QW = (RW > FRF_W) ? RW : FRF_W;
    localparam int NW = CARRIER_W + FRF_SHIFT;
    localparam logic [63:0] RECIP_WIDE = (64'd1 << (FRF_SHIFT + 32)) / 64'(CRYSTAL_HZ);
    localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
    localparam logic [CW-1:0] DIVISOR = CW'(CRYSTAL_HZ);

    logic [63:0]       est_prod;
    logic [NW-1:0]     numer;
    logic [QW-1:0]     q_est_reg;
    logic [RW-1:0]     numer_low_reg;
    logic [RW+CW-1:0]  back_prod;
    logic [RW-1:0]     rem_next;
    logic [RW-1:0]     rem_reg;
    logic [FRF_W-1:0]  q_low_reg;

    // The truncated reciprocal underestimates the quotient by at most one.
    assign est_prod = {32'd0, carrier_hz} * {32'd0, RECIP};
    assign numer    = {carrier_hz, {FRF_SHIFT{1'b0}}};

    always_ff @(posedge clk)
    begin
        q_est_reg     <= est_prod[32 +: QW];
        numer_low_reg <= numer[RW-1:0];
    end

    // The remainder stays below twice the divisor, so its low bits are enough.
    assign back_prod = {{CW{1'b0}}, q_est_reg[RW-1:0]} * {{RW{1'b0}}, DIVISOR};
    assign rem_next  = numer_low_reg - back_prod[RW-1:0];

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        q_low_reg <= q_est_reg[FRF_W-1:0];
    end

    assign frf_word = q_low_reg + FRF_W'(rem_reg >= {1'b0, DIVISOR});

endmodule

`default_nettype wire

/* src/rsre_modem_enc.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsre_modem_enc
    import rsre_pkg::*;
(
    input  wire logic         clk,
    input  wire logic [1:0]   bandwidth_code,
    input  wire logic [3:0]   spread_factor,
    input  wire radio_cfg_t   radio_cfg,
    output modem_words_t      words
);

    logic         long_symbols;
    logic [7:0]   sf_bits;
    logic [7:0]   bw_new;
    logic [7:0]   bw_old;
    modem_words_t words_next;
    modem_words_t stage_a_reg;
    modem_words_t stage_b_reg;

    assign long_symbols = (bandwidth_code == BW_125K)
                          && ((spread_factor == SF_11) || (spread_factor == SF_12));

    always_comb
    begin
        if ((spread_factor >= SF_MIN) && (spread_factor <= SF_MAX))
        begin
            sf_bits = {spread_factor, 4'd0};
        end
        else
        begin
            sf_bits = SF_DEFAULT_BITS;
        end

        case (bandwidth_code)
            BW_250K:
            begin
                bw_new = BW_NEW_250K;
                bw_old = BW_OLD_250K;
            end
            BW_500K:
            begin
                bw_new = BW_NEW_500K;
                bw_old = BW_OLD_500K;
            end
            default:
            begin
                bw_new = BW_NEW_125K;
                bw_old = BW_OLD_125K;
            end
        endcase

        words_next.cfg2 = sf_bits | CFG2_FIXED;
        if (radio_cfg.newer)
        begin
            words_next.cfg1       = bw_new | CFG1_IMPLICIT_CR;
            words_next.cfg3       = (long_symbols ? CFG3_LOWRATE : 8'd0) | CFG3_AGC;
            words_next.cfg3_valid = 1'b1;
        end
        else
        begin
            words_next.cfg1       = bw_old | CFG1_OLD_CRC | CFG1_IMPLICIT_CR
                                    | (long_symbols ? CFG1_OLD_LOWRATE : 8'd0);
            words_next.cfg3       = 8'd0;
            words_next.cfg3_valid = 1'b0;
        end
    end

    // Two stages keep the words in step with the carrier divider.
    always_ff @(posedge clk)
    begin
        stage_a_reg <= words_next;
        stage_b_reg <= stage_a_reg;
    end

    assign words = stage_b_reg;

endmodule

`default_nettype wire

/* src/rsre_pa_enc.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsre_pa_enc
    import rsre_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [15:0] power_centi_dbm,
    input  wire logic               is_transmit,
    input  wire logic [7:0]         old_pa_config,
    input  wire logic [7:0]         old_pa_dac,
    input  wire radio_cfg_t         radio_cfg,
    output pa_words_t               words
);

    logic [15:0]              mag;
    logic [28:0]              scale_prod;
    logic [DBM_W-1:0]         quot;
    logic signed [DBM_W-1:0]  dbm_next;
    logic signed [DBM_W-1:0]  dbm_reg;
    logic                     tx_reg;
    logic [7:0]               old_cfg_reg;
    logic [7:0]               old_dac_reg;
    logic [3:0]               nib;
    pa_words_t                words_next;
    pa_words_t                words_reg;

    // Divide the magnitude and restore the sign: truncation toward zero.
    assign mag        = power_centi_dbm[15] ? 16'(-power_centi_dbm) : 16'(power_centi_dbm);
    assign scale_prod = {13'd0, mag} * {16'd0, CENTI_RECIP};
    assign quot       = DBM_W'(scale_prod[28:CENTI_SHIFT]);
    assign dbm_next   = power_centi_dbm[15] ? -$signed(quot) : $signed(quot);

    always_ff @(posedge clk)
    begin
        dbm_reg     <= dbm_next;
        tx_reg      <= is_transmit;
        old_cfg_reg <= old_pa_config;
        old_dac_reg <= old_pa_dac;
    end

    always_comb
    begin
        words_next = '0;
        nib        = NIB_MIN;
        if (tx_reg)
        begin
            words_next.config_valid = 1'b1;
            if (radio_cfg.boost)
            begin
                words_next.dac_valid = 1'b1;
                if (dbm_reg >= 11'sd20)
                begin
                    nib                = NIB_MAX;
                    words_next.pa_dac  = (old_dac_reg & DAC_KEEP) | DAC_BOOST_ON;
                end
                else
                begin
                    if (dbm_reg > 11'sd17)
                    begin
                        nib = NIB_MAX;
                    end
                    else if (dbm_reg < 11'sd2)
                    begin
                        nib = NIB_MIN;
                    end
                    else
                    begin
                        nib = 4'(dbm_reg - 11'sd2);
                    end
                    words_next.pa_dac = (old_dac_reg & DAC_KEEP) | DAC_BOOST_OFF;
                end
                if (radio_cfg.newer)
                begin
                    words_next.pa_config = PA_SELECT | {4'd0, nib};
                end
                else
                begin
                    words_next.pa_config = (old_cfg_reg & PA_HIGH_NIBBLE) | PA_SELECT
                                           | {4'd0, nib};
                end
            end
            else if (radio_cfg.newer)
            begin
                // The newer part on the RFO pin always runs at its fixed setting.
                words_next.pa_config = (old_cfg_reg & PA_HIGH_NIBBLE) | PA_RFO_NEWER;
            end
            else
            begin
                if (dbm_reg > 11'sd14)
                begin
                    nib = NIB_MAX;
                end
                else if (dbm_reg < -11'sd1)
                begin
                    nib = NIB_MIN;
                end
                else
                begin
                    nib = 4'(dbm_reg + 11'sd1);
                end
                words_next.pa_config = (old_cfg_reg & PA_MAX_POWER) | {4'd0, nib};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

    assign words = words_reg;

endmodule

`default_nettype wire

/* src/radio_setting_register_encoder.sv */
// A request is registered at the inputs, through the pipelined stages and at the outputs.
// Throughput: one request per cycle; busy is never raised.
// The carrier divider and the power scaler are pipelined multiplies, which set the latency.
// Reset (rst_n low, asynchronous) clears the pipeline valid bits and both config registers.
// The receiver cannot stall: each result beat is on the ports for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module radio_setting_register_encoder
    import rsre_pkg::*;
#(
    parameter int CRYSTAL_HZ = 32000000
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    output logic                      done,
    input  wire logic [31:0]          carrier_hz,
    input  wire logic [1:0]           bandwidth_code,
    input  wire logic [3:0]           spread_factor,
    input  wire logic signed [15:0]   power_centi_dbm,
    input  wire logic                 is_transmit,
    input  wire logic [7:0]           old_pa_config,
    input  wire logic [7:0]           old_pa_dac,
    output logic [23:0]               frf_word,
    output logic [7:0]                modem_cfg1,
    output logic [7:0]                modem_cfg2,
    output logic [7:0]                modem_cfg3,
    output logic                      modem_cfg3_valid,
    output logic [7:0]                pa_config_out,
    output logic [7:0]                pa_dac_out,
    output logic                      pa_config_valid,
    output logic                      pa_dac_valid,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic         chip_variant_reg;
    logic         amp_path_reg;
    logic         cfg_write;
    radio_cfg_t   radio_cfg;

    logic         in_valid_reg;
    logic [31:0]  carrier_reg;
    logic [1:0]   bw_reg;
    logic [3:0]   sf_reg;
    logic [15:0]  power_reg;
    logic         tx_reg;
    logic [7:0]   old_cfg_reg;
    logic [7:0]   old_dac_reg;
    logic         stage_a_valid_reg;
    logic         stage_b_valid_reg;
    logic         done_reg;

    logic [FRF_W-1:0] frf_next;
    modem_words_t     modem_next;
    pa_words_t        pa_next;
    logic [FRF_W-1:0] frf_reg;
    modem_words_t     modem_reg;
    pa_words_t        pa_reg;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_variant_reg <= 1'b0;
            amp_path_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_CHIP_VARIANT: chip_variant_reg <= pwdata[0];
                REG_AMP_PATH:     amp_path_reg     <= pwdata[0];
                default:          chip_variant_reg <= chip_variant_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CHIP_VARIANT: prdata = {31'd0, chip_variant_reg};
            REG_AMP_PATH:     prdata = {31'd0, amp_path_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign radio_cfg.newer = chip_variant_reg;
    assign radio_cfg.boost = amp_path_reg;

    // The valid bits walk alongside the free-running data pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            stage_a_valid_reg <= 1'b0;
            stage_b_valid_reg <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            in_valid_reg      <= start && !busy;
            stage_a_valid_reg <= in_valid_reg;
            stage_b_valid_reg <= stage_a_valid_reg;
            done_reg          <= stage_b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        carrier_reg <= carrier_hz;
        bw_reg      <= bandwidth_code;
        sf_reg      <= spread_factor;
        power_reg   <= power_centi_dbm;
        tx_reg      <= is_transmit;
        old_cfg_reg <= old_pa_config;
        old_dac_reg <= old_pa_dac;
    end

    rsre_frf_div #(
        .CRYSTAL_HZ (CRYSTAL_HZ)
    ) u_frf_div (
        .clk        (clk),
        .carrier_hz (carrier_reg),
        .frf_word   (frf_next)
    );

    rsre_modem_enc u_modem_enc (
        .clk            (clk),
        .bandwidth_code (bw_reg),
        .spread_factor  (sf_reg),
        .radio_cfg      (radio_cfg),
        .words          (modem_next)
    );

    rsre_pa_enc u_pa_enc (
        .clk             (clk),
        .power_centi_dbm ($signed(power_reg)),
        .is_transmit     (tx_reg),
        .old_pa_config   (old_cfg_reg),
        .old_pa_dac      (old_dac_reg),
        .radio_cfg       (radio_cfg),
        .words           (pa_next)
    );

    always_ff @(posedge clk)
    begin
        frf_reg   <= frf_next;
        modem_reg <= modem_next;
        pa_reg    <= pa_next;
    end

    assign done             = done_reg;
    assign frf_word         = frf_reg;
    assign modem_cfg1       = modem_reg.cfg1;
    assign modem_cfg2       = modem_reg.cfg2;
    assign modem_cfg3       = modem_reg.cfg3;
    assign modem_cfg3_valid = modem_reg.cfg3_valid;
    assign pa_config_out    = pa_reg.pa_config;
    assign pa_dac_out       = pa_reg.pa_dac;
    assign pa_config_valid  = pa_reg.config_valid;
    assign pa_dac_valid     = pa_reg.dac_valid;

endmodule

`default_nettype wire

/* src/rsre_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsre_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic [7:0]  modem_cfg3,
    input  wire logic        modem_cfg3_valid,
    input  wire logic [7:0]  pa_config_out,
    input  wire logic [7:0]  pa_dac_out,
    input  wire logic        pa_config_valid,
    input  wire logic        pa_dac_valid
);

    // Every accepted request produces its result beat.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted request produced no result beat");

    // No result beat appears without an earlier accepted request to match it.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result beat without a matching request");

    a_cfg3_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !modem_cfg3_valid) |-> (modem_cfg3 == 8'd0))
        else $error("modem config 3 nonzero on the older variant");

    a_receive_pa: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pa_config_valid)
        |-> (pa_config_out == 8'd0 && pa_dac_out == 8'd0 && !pa_dac_valid))
        else $error("PA fields set on a receive request");

    a_dac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !pa_dac_valid) |-> (pa_dac_out == 8'd0))
        else $error("PA DAC byte nonzero without its valid flag");

endmodule

bind radio_setting_register_encoder rsre_checker u_rsre_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .modem_cfg3       (modem_cfg3),
    .modem_cfg3_valid (modem_cfg3_valid),
    .pa_config_out    (pa_config_out),
    .pa_dac_out       (pa_dac_out),
    .pa_config_valid  (pa_config_valid),
    .pa_dac_valid     (pa_dac_valid)
);

`default_nettype wire
